FILE: hw/rtl/ecal_pkg.sv
`default_nettype none

package ecal_pkg;

    // widths of the fixed fields
    localparam int unsigned TS_W    = 32;
    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned WDAY_W  = 3;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned SEC_W   = 6;

    // internal quotient widths
    localparam int unsigned Q60_W   = 27;  // seconds / 60
    localparam int unsigned Q3600_W = 21;  // seconds / 3600
    localparam int unsigned DAYS_W  = 16;  // whole days since epoch
    localparam int unsigned WX_W    = 17;  // days + epoch weekday
    localparam int unsigned WQ_W    = 13;  // (days + 4) / 7
    localparam int unsigned DOE_W   = 18;  // day of 400-year era
    localparam int unsigned DOC_W   = 16;  // day of century
    localparam int unsigned Q4_W    = 5;   // four-year cycle in century
    localparam int unsigned REM4_W  = 11;  // day of four-year cycle
    localparam int unsigned DOY_W   = 9;   // day of march-based year

    // reciprocals for constant division
    localparam logic [63:0] RECIP_60   = 64'h0000_0000_8888_8889;  // >> 37
    localparam logic [63:0] RECIP_24   = 64'd1398102;              // >> 25
    localparam logic [63:0] RECIP_7    = 64'd149797;               // >> 20
    localparam logic [31:0] RECIP_1461 = 32'd45934;                // >> 26

    localparam logic [31:0] SECS_PER_MIN  = 32'd60;
    localparam logic [26:0] MINS_PER_HOUR = 27'd60;
    localparam logic [20:0] HOURS_PER_DAY = 21'd24;
    localparam logic [WX_W-1:0]  EPOCH_WEEKDAY = 17'd4;
    localparam logic [WX_W-1:0]  DAYS_PER_WEEK = 17'd7;
    localparam logic [WDAY_W-1:0] SUNDAY       = 3'd7;

    // 2000-03-01 as a day count from 1970-01-01, and the era length
    localparam logic [DAYS_W-1:0] ERA5_START   = 16'd11017;
    localparam logic [DOE_W-1:0]  ERA4_OFFSET  = 18'd135080;  // 146097 - 11017
    localparam logic [YEAR_W-1:0] ERA4_YEAR    = 12'd1600;
    localparam logic [YEAR_W-1:0] ERA5_YEAR    = 12'd2000;

    localparam logic [DOE_W-1:0]  DAYS_PER_CENT = 18'd36524;
    localparam logic [REM4_W-1:0] DAYS_PER_CYC  = 11'd1461;
    localparam logic [REM4_W-1:0] DAYS_COMMON   = 11'd365;
    localparam logic [3:0]        JAN_MP        = 4'd10;  // first month of next year

    typedef struct packed {
        logic                zero;
        logic [HOUR_W-1:0]   hour;
        logic [MIN_W-1:0]    minute;
        logic [SEC_W-1:0]    second;
    } ecal_tod_t;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day_of_month;
        logic [WDAY_W-1:0]   weekday;
    } ecal_date_t;

    // first day of each month in a year that starts on march 1
    function automatic logic [DOY_W-1:0] month_start(input logic [3:0] mp);
        logic [DOY_W-1:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/epoch_seconds_to_calendar.sv
// throughput: one word per cycle; the whole pipeline holds while m_tvalid
//   is high and m_tready is low
// reset: rst_n is asynchronous and active low; it clears the stage valid
//   bits only, so no output word appears until new input is taken
`default_nettype none

module epoch_seconds_to_calendar
    import ecal_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] timestamp_seconds

    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // [11:0] year, [15:12] month,
                                        // [20:16] day_of_month, [23:21] weekday,
                                        // [28:24] hour, [34:29] minute,
                                        // [40:35] second, [47:41] zero
);

    // one enable for every stage: the pipeline moves whenever the last
    // stage is empty or its word is being taken
    logic                 en;
    logic                 tod_valid;
    ecal_tod_t            tod;
    logic [DAYS_W-1:0]    days;
    ecal_tod_t            out_tod;
    ecal_date_t           out_date;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // seconds -> second, minute, hour and whole days
    // (three reciprocal multiplies, four stages)
    ecal_tod u_tod (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_ts     (s_tdata[TS_W-1:0]),
        .out_valid (tod_valid),
        .out_tod   (tod),
        .out_days  (days)
    );

    // days -> weekday and gregorian year, month, day
    // (400-year era, century, four-year cycle, year, month; six stages)
    ecal_date u_date (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (tod_valid),
        .in_days   (days),
        .in_tod    (tod),
        .out_valid (m_tvalid),
        .out_tod   (out_tod),
        .out_date  (out_date)
    );

    // pack the output word, first field in the low bits
    assign m_tdata = {7'd0,
                      out_tod.second,
                      out_tod.minute,
                      out_tod.hour,
                      out_date.weekday,
                      out_date.day_of_month,
                      out_date.month,
                      out_date.year};

endmodule

`default_nettype wire

FILE: hw/rtl/ecal_tod.sv
`default_nettype none

module ecal_tod
    import ecal_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [TS_W-1:0]   in_ts,
    output logic                   out_valid,
    output ecal_tod_t              out_tod,
    output logic [DAYS_W-1:0]      out_days
);

    logic [2:0]           vld_reg;

    // stage 1
    logic [63:0]          p60a;
    logic [Q60_W-1:0]     q60_next;
    logic [TS_W-1:0]      ts1_reg;
    logic [Q60_W-1:0]     q60_1_reg;

    // stage 2
    logic [63:0]          p60b;
    logic [TS_W-1:0]      sec_diff;
    logic [Q3600_W-1:0]   q3600_next;
    logic                 zero2_reg;
    logic [SEC_W-1:0]     sec2_reg;
    logic [Q60_W-1:0]     q60_2_reg;
    logic [Q3600_W-1:0]   q3600_2_reg;

    // stage 3
    logic [63:0]          p24;
    logic [Q60_W-1:0]     min_diff;
    logic [DAYS_W-1:0]    days_next;
    logic                 zero3_reg;
    logic [SEC_W-1:0]     sec3_reg;
    logic [MIN_W-1:0]     min3_reg;
    logic [Q3600_W-1:0]   q3600_3_reg;
    logic [DAYS_W-1:0]    days3_reg;

    // stage 4
    logic [Q3600_W-1:0]   hour_diff;
    ecal_tod_t            tod_next;
    ecal_tod_t            tod_reg;
    logic [DAYS_W-1:0]    days4_reg;

    assign p60a     = {32'd0, in_ts} * RECIP_60;
    assign q60_next = p60a[63:37];

    assign sec_diff   = ts1_reg - 32'(q60_1_reg) * SECS_PER_MIN;
    assign p60b       = {37'd0, q60_1_reg} * RECIP_60;
    assign q3600_next = p60b[57:37];

    assign min_diff  = q60_2_reg - 27'(q3600_2_reg) * MINS_PER_HOUR;
    assign p24       = {43'd0, q3600_2_reg} * RECIP_24;
    assign days_next = p24[40:25];

    assign hour_diff = q3600_3_reg - 21'(days3_reg) * HOURS_PER_DAY;

    always_comb
    begin
        tod_next.zero   = zero3_reg;
        tod_next.hour   = hour_diff[HOUR_W-1:0];
        tod_next.minute = min3_reg;
        tod_next.second = sec3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            vld_reg   <= {vld_reg[1:0], in_valid};
            out_valid <= vld_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ts1_reg     <= in_ts;
            q60_1_reg   <= q60_next;

            zero2_reg   <= (ts1_reg == '0);
            sec2_reg    <= sec_diff[SEC_W-1:0];
            q60_2_reg   <= q60_1_reg;
            q3600_2_reg <= q3600_next;

            zero3_reg   <= zero2_reg;
            sec3_reg    <= sec2_reg;
            min3_reg    <= min_diff[MIN_W-1:0];
            q3600_3_reg <= q3600_2_reg;
            days3_reg   <= days_next;

            tod_reg     <= tod_next;
            days4_reg   <= days3_reg;
        end
    end

    assign out_tod  = tod_reg;
    assign out_days = days4_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/ecal_date.sv
`default_nettype none

module ecal_date
    import ecal_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [DAYS_W-1:0] in_days,
    input  wire ecal_tod_t         in_tod,
    output logic                   out_valid,
    output ecal_tod_t              out_tod,
    output ecal_date_t             out_date
);

    logic [4:0]           vld_reg;

    // stage 1: weekday quotient and era
    logic [WX_W-1:0]      wx_next;
    logic [63:0]          p7;
    logic                 era5_next;
    logic [DOE_W-1:0]     doe_next;
    ecal_tod_t            tod1_reg;
    logic [WX_W-1:0]      wx1_reg;
    logic [WQ_W-1:0]      wq1_reg;
    logic                 era5_1_reg;
    logic [DOE_W-1:0]     doe1_reg;

    // stage 2: weekday, century
    logic [WX_W-1:0]      wrem;
    logic [WDAY_W-1:0]    wd_next;
    logic [1:0]           cent_next;
    logic [DOE_W-1:0]     cent_base;
    logic [DOE_W-1:0]     doc_diff;
    ecal_tod_t            tod2_reg;
    logic [WDAY_W-1:0]    wd2_reg;
    logic                 era5_2_reg;
    logic [1:0]           cent2_reg;
    logic [DOC_W-1:0]     doc2_reg;

    // stage 3: four-year cycle
    logic [31:0]          p1461;
    ecal_tod_t            tod3_reg;
    logic [WDAY_W-1:0]    wd3_reg;
    logic                 era5_3_reg;
    logic [1:0]           cent3_reg;
    logic [DOC_W-1:0]     doc3_reg;
    logic [Q4_W-1:0]      q4_3_reg;

    // stage 4: day of cycle
    logic [DOC_W-1:0]     rem4_diff;
    ecal_tod_t            tod4_reg;
    logic [WDAY_W-1:0]    wd4_reg;
    logic                 era5_4_reg;
    logic [1:0]           cent4_reg;
    logic [Q4_W-1:0]      q4_4_reg;
    logic [REM4_W-1:0]    rem4_4_reg;

    // stage 5: year of cycle, day of year
    logic [1:0]           yr_next;
    logic [REM4_W-1:0]    yr_base;
    logic [REM4_W-1:0]    doy_diff;
    logic [YEAR_W-1:0]    ypart_next;
    ecal_tod_t            tod5_reg;
    logic [WDAY_W-1:0]    wd5_reg;
    logic [DOY_W-1:0]     doy5_reg;
    logic [YEAR_W-1:0]    ypart5_reg;

    // stage 6: month and day
    logic [3:0]           mp;
    logic [DOY_W-1:0]     day_diff;
    ecal_date_t           date_next;
    ecal_tod_t            tod6_reg;
    ecal_date_t           date6_reg;

    // weekday: 1970-01-01 was a thursday
    assign wx_next   = WX_W'(in_days) + EPOCH_WEEKDAY;
    assign p7        = {47'd0, wx_next} * RECIP_7;
    // days from 2000-03-01 or from 1600-03-01
    assign era5_next = (in_days >= ERA5_START);
    assign doe_next  = era5_next ? DOE_W'(in_days - ERA5_START)
                                 : DOE_W'(in_days) + ERA4_OFFSET;

    assign wrem    = wx1_reg - WX_W'(wq1_reg) * DAYS_PER_WEEK;
    assign wd_next = (wrem[WDAY_W-1:0] == '0) ? SUNDAY : wrem[WDAY_W-1:0];

    // only the last century of an era has a leap day at its end
    always_comb
    begin
        if (doe1_reg >= DOE_W'(3) * DAYS_PER_CENT)
            cent_next = 2'd3;
        else if (doe1_reg >= DOE_W'(2) * DAYS_PER_CENT)
            cent_next = 2'd2;
        else if (doe1_reg >= DAYS_PER_CENT)
            cent_next = 2'd1;
        else
            cent_next = 2'd0;
    end

    assign cent_base = DOE_W'(cent_next) * DAYS_PER_CENT;
    assign doc_diff  = doe1_reg - cent_base;

    assign p1461 = {16'd0, doc2_reg} * RECIP_1461;

    assign rem4_diff = doc3_reg - DOC_W'(q4_3_reg) * DOC_W'(DAYS_PER_CYC);

    // the fourth year of a cycle takes the leap day
    always_comb
    begin
        if (rem4_4_reg >= REM4_W'(3) * DAYS_COMMON)
            yr_next = 2'd3;
        else if (rem4_4_reg >= REM4_W'(2) * DAYS_COMMON)
            yr_next = 2'd2;
        else if (rem4_4_reg >= DAYS_COMMON)
            yr_next = 2'd1;
        else
            yr_next = 2'd0;
    end

    assign yr_base    = REM4_W'(yr_next) * DAYS_COMMON;
    assign doy_diff   = rem4_4_reg - yr_base;
    assign ypart_next = (era5_4_reg ? ERA5_YEAR : ERA4_YEAR)
                      + YEAR_W'(cent4_reg) * 12'd100
                      + {5'd0, q4_4_reg, 2'b00}
                      + YEAR_W'(yr_next);

    always_comb
    begin
        mp = 4'd0;
        for (int i = 1; i < 12; i++)
        begin
            if (doy5_reg >= month_start(4'(i)))
                mp = 4'(i);
        end
    end

    assign day_diff = doy5_reg - month_start(mp) + 9'd1;

    always_comb
    begin
        if (tod5_reg.zero)
        begin
            date_next = '0;
        end
        else
        begin
            date_next.year         = ypart5_reg + YEAR_W'(mp >= JAN_MP);
            date_next.month        = (mp >= JAN_MP) ? mp - 4'd9 : mp + 4'd3;
            date_next.day_of_month = day_diff[DAY_W-1:0];
            date_next.weekday      = wd5_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            vld_reg   <= {vld_reg[3:0], in_valid};
            out_valid <= vld_reg[4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tod1_reg   <= in_tod;
            wx1_reg    <= wx_next;
            wq1_reg    <= p7[32:20];
            era5_1_reg <= era5_next;
            doe1_reg   <= doe_next;

            tod2_reg   <= tod1_reg;
            wd2_reg    <= wd_next;
            era5_2_reg <= era5_1_reg;
            cent2_reg  <= cent_next;
            doc2_reg   <= doc_diff[DOC_W-1:0];

            tod3_reg   <= tod2_reg;
            wd3_reg    <= wd2_reg;
            era5_3_reg <= era5_2_reg;
            cent3_reg  <= cent2_reg;
            doc3_reg   <= doc2_reg;
            q4_3_reg   <= p1461[30:26];

            tod4_reg   <= tod3_reg;
            wd4_reg    <= wd3_reg;
            era5_4_reg <= era5_3_reg;
            cent4_reg  <= cent3_reg;
            q4_4_reg   <= q4_3_reg;
            rem4_4_reg <= rem4_diff[REM4_W-1:0];

            tod5_reg   <= tod4_reg;
            wd5_reg    <= wd4_reg;
            doy5_reg   <= doy_diff[DOY_W-1:0];
            ypart5_reg <= ypart_next;

            tod6_reg   <= tod5_reg;
            date6_reg  <= date_next;
        end
    end

    assign out_tod  = tod6_reg;
    assign out_date = date6_reg;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`default_nettype none

module tb;
    import ecal_pkg::*;

    // run shape
    localparam int unsigned RANDOM_ITEMS  = 1250;
    localparam int unsigned QUIET_TAIL    = 120;   // last words go with no idling
    localparam int unsigned HOLD_AFTER    = 300;   // results seen before the long hold
    localparam int unsigned HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int unsigned DRAIN_CYCLES  = 20;    // pipeline is 10 deep
    localparam int unsigned STALL_LIMIT   = 3000;  // cycles with no word moving

    // one expected calendar word, fields at the block's widths
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day_of_month;
        logic [WDAY_W-1:0]  weekday;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } calendar_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;      // [31:0] timestamp_seconds

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // [11:0] year, [15:12] month, [20:16] day_of_month,
                                    // [23:21] weekday, [28:24] hour, [34:29] minute,
                                    // [40:35] second, [47:41] zero

    // timestamps waiting to be offered, and calendar words waiting to come out
    logic [31:0] timestamp_queue[$];
    calendar_t   calendar_expected[$];

    int unsigned item_total = 0;
    int unsigned received_count = 0;
    int unsigned error_count = 0;

    // sender and receiver idle state
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;
    int unsigned stall_cycles = 0;

    calendar_t   want;

    epoch_seconds_to_calendar dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // full gregorian rule: every 4th year, except centuries not divisible by 400
    function automatic logic is_gregorian_leap(input int unsigned yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    // seconds since 1970-01-01 to the calendar word the block should produce
    function automatic calendar_t epoch_to_calendar(input logic [31:0] ts);
        calendar_t   c;
        int unsigned rest;
        int unsigned days;
        int unsigned yr;
        int unsigned mo;
        int unsigned mlen;
        logic        leap;
        c = '0;
        // zero means the time is not known yet: every field stays zero
        if (ts == 32'd0)
            return c;
        rest = ts;
        c.second = SEC_W'(rest % 60);
        rest = rest / 60;
        c.minute = MIN_W'(rest % 60);
        rest = rest / 60;
        c.hour = HOUR_W'(rest % 24);
        days = rest / 24;
        // 1970-01-01 was a thursday; monday is 1, sunday 7
        c.weekday = WDAY_W'((days % 7 + 4) % 7);
        if (c.weekday == 0)
            c.weekday = WDAY_W'(7);
        // peel off whole years
        yr = 1970;
        while (days >= (is_gregorian_leap(yr) ? 366 : 365))
        begin
            days = days - (is_gregorian_leap(yr) ? 366 : 365);
            yr = yr + 1;
        end
        leap = is_gregorian_leap(yr);
        // then whole months, december takes the remainder
        mo = 0;
        while (mo < 11)
        begin
            case (mo)
                1:       mlen = leap ? 29 : 28;
                3, 5, 8, 10: mlen = 30;
                default: mlen = 31;
            endcase
            if (days < mlen)
                break;
            days = days - mlen;
            mo = mo + 1;
        end
        c.year = YEAR_W'(yr);
        c.month = MONTH_W'(mo + 1);
        c.day_of_month = DAY_W'(days + 1);
        return c;
    endfunction

    // driver: offers the queued timestamps, with random idle bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end
        else
        begin
            // a word taken now gets its expected calendar word
            if (s_tvalid && s_tready)
                calendar_expected.push_back(epoch_to_calendar(s_tdata));
            // the offered word may only change once it has been taken
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (timestamp_queue.size() == 0)
                    s_tvalid <= 1'b0;
                else if (timestamp_queue.size() > QUIET_TAIL && $urandom_range(0, 11) == 0)
                begin
                    // idle burst of random length, this cycle included
                    send_gap <= $urandom_range(0, 17);
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= timestamp_queue.pop_front();
                end
            end
        end
    end

    // monitor: takes calendar words, checks each against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            recv_gap  <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                received_count++;
                if (calendar_expected.size() == 0)
                begin
                    $error("calendar word %h with no expectation waiting", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = calendar_expected.pop_front();
                    if (m_tdata[11:0] !== want.year)
                    begin
                        $error("year: expected %0d, actual %0d", want.year, m_tdata[11:0]);
                        error_count++;
                    end
                    if (m_tdata[15:12] !== want.month)
                    begin
                        $error("month: expected %0d, actual %0d", want.month, m_tdata[15:12]);
                        error_count++;
                    end
                    if (m_tdata[20:16] !== want.day_of_month)
                    begin
                        $error("day_of_month: expected %0d, actual %0d",
                               want.day_of_month, m_tdata[20:16]);
                        error_count++;
                    end
                    if (m_tdata[23:21] !== want.weekday)
                    begin
                        $error("weekday: expected %0d, actual %0d", want.weekday, m_tdata[23:21]);
                        error_count++;
                    end
                    if (m_tdata[28:24] !== want.hour)
                    begin
                        $error("hour: expected %0d, actual %0d", want.hour, m_tdata[28:24]);
                        error_count++;
                    end
                    if (m_tdata[34:29] !== want.minute)
                    begin
                        $error("minute: expected %0d, actual %0d", want.minute, m_tdata[34:29]);
                        error_count++;
                    end
                    if (m_tdata[40:35] !== want.second)
                    begin
                        $error("second: expected %0d, actual %0d", want.second, m_tdata[40:35]);
                        error_count++;
                    end
                    if (m_tdata[47:41] !== 7'd0)
                    begin
                        $error("zero fill: expected 0, actual %h", m_tdata[47:41]);
                        error_count++;
                    end
                end
            end
            // ready pattern: one long hold to fill the pipe, then random bursts
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else if (!hold_done && received_count >= HOLD_AFTER)
            begin
                hold_left <= HOLD_CYCLES - 1;
                hold_done <= 1'b1;
                m_tready  <= 1'b0;
            end
            else if (recv_gap != 0)
            begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end
            else if (item_total - received_count > QUIET_TAIL && $urandom_range(0, 11) == 0)
            begin
                recv_gap <= $urandom_range(0, 17);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog: too long with no word moving on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin : stimulus
        int unsigned n;
        int unsigned pick;
        logic [31:0] ts;

        // directed: field extremes and calendar corners
        timestamp_queue.push_back(32'd0);            // time not known yet
        timestamp_queue.push_back(32'd1);            // first second of the epoch
        timestamp_queue.push_back(32'hFFFF_FFFF);    // last value, 2106-02-07
        timestamp_queue.push_back(32'd59);
        timestamp_queue.push_back(32'd60);
        timestamp_queue.push_back(32'd3599);
        timestamp_queue.push_back(32'd3600);
        timestamp_queue.push_back(32'd86399);        // end of first day
        timestamp_queue.push_back(32'd86400);
        timestamp_queue.push_back(32'd31535999);     // 1970-12-31 23:59:59
        timestamp_queue.push_back(32'd68169600);     // 1972-02-29
        timestamp_queue.push_back(32'd951782400);    // 2000-02-29, century leap
        timestamp_queue.push_back(32'd951868799);
        timestamp_queue.push_back(32'd978307199);    // 2000-12-31, day 366
        timestamp_queue.push_back(32'd4102444799);   // 2099-12-31 23:59:59
        timestamp_queue.push_back(32'd4107542399);   // 2100-02-28, no leap day
        timestamp_queue.push_back(32'd4107542400);   // 2100-03-01
        timestamp_queue.push_back(32'h7FFF_FFFF);
        timestamp_queue.push_back(32'h8000_0000);

        // random: full range, whole days with random time, and bit patterns
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                ts = $urandom;
            else if (pick < 8)
                ts = $urandom_range(0, 49709) * 86400 + $urandom_range(0, 86399);
            else if (pick == 8)
                ts = 32'd1 << $urandom_range(0, 31);
            else
                ts = ~(32'd1 << $urandom_range(0, 31));
            timestamp_queue.push_back(ts);
        end
        item_total = timestamp_queue.size();

        // single reset at the start
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (received_count < item_total)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (calendar_expected.size() != 0)
        begin
            $error("%0d calendar words never came out", calendar_expected.size());
            error_count++;
        end

        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
hw/rtl/ecal_pkg.sv
hw/rtl/ecal_tod.sv
hw/rtl/ecal_date.sv
hw/rtl/epoch_seconds_to_calendar.sv
tb/sv/tb.sv
